// ===== rtl/wfqp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the word FIFO with quadword pad.
package wfqp_pkg;

   localparam int WORD_W     = 32;
   localparam int QUAD_WORDS = 4;

   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_POP  = 2'd1;
   localparam logic [1:0] ACT_PAD  = 2'd2;

   localparam logic [1:0] FAULT_OK        = 2'd0;
   localparam logic [1:0] FAULT_OVERFLOW  = 2'd1;
   localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;

   typedef enum logic {
      ADDR_INC,
      ADDR_BACK4
   } addr_op_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [2:0]        word_count;
      logic [WORD_W-1:0] word_a;
      logic [WORD_W-1:0] word_b;
      logic [WORD_W-1:0] word_c;
      logic [WORD_W-1:0] word_d;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_word_a;
      logic [WORD_W-1:0] out_word_b;
      logic [WORD_W-1:0] out_word_c;
      logic [WORD_W-1:0] out_word_d;
      logic [7:0]        fill_level;
      logic [1:0]        fault;
   } rsp_type;

endpackage

// ===== rtl/wfqp_ring.sv =====
`timescale 1ns / 1ps
// Ring storage: one write port, one read port with registered read data.
module wfqp_ring import wfqp_pkg::*; #(
   parameter int RING_DEPTH = 128,
   localparam int PTR_W = $clog2(RING_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [PTR_W-1:0]  wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [PTR_W-1:0]  rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [RING_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wfqp_addr_unit.sv =====
`timescale 1ns / 1ps
// Shared ring pointer unit: step forward one word or back one quadword, with wrap.
module wfqp_addr_unit import wfqp_pkg::*; #(
   parameter int RING_DEPTH = 128,
   localparam int PTR_W = $clog2(RING_DEPTH)
) (
   input  addr_op_type       op,
   input  logic [PTR_W-1:0]  ptr_in,
   output logic [PTR_W-1:0]  ptr_out
);

   localparam logic [PTR_W-1:0] LAST      = PTR_W'(RING_DEPTH - 1);
   localparam logic [PTR_W-1:0] BACK      = PTR_W'(QUAD_WORDS);
   localparam logic [PTR_W-1:0] WRAP_BACK = PTR_W'(RING_DEPTH - QUAD_WORDS);

   always_comb begin
      unique case (op)
         ADDR_INC: begin
            ptr_out = (ptr_in == LAST) ? '0 : ptr_in + PTR_W'(1);
         end
         ADDR_BACK4: begin
            ptr_out = (ptr_in >= BACK) ? ptr_in - BACK : ptr_in + WRAP_BACK;
         end
         default: begin
            ptr_out = ptr_in;
         end
      endcase
   end

endmodule

// ===== rtl/word_fifo_with_quadword_pad_unit.sv =====
`timescale 1ns / 1ps
// Word FIFO with quadword pad: one word per step through a single ring and pointer unit.
// Steps: a push writes one word in each ST_PUSH state; a pop or pad spends a read state
// and a capture or write state on each word; every item, also one moving no word, ends
// in ST_DONE. One item at a time: no request is taken until the last has left ST_DONE.
// Reset: a clearing pass writes zero to every ring word, with req_stall high. A result
// waiting in the output register does not hold up the next request.
module word_fifo_with_quadword_pad_unit import wfqp_pkg::*; #(
   parameter int RING_DEPTH = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PUSH,
      ST_POP_RD,
      ST_POP_CAP,
      ST_PAD_RD,
      ST_PAD_WR,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [PTR_W-1:0]  wp_ff;
   logic [PTR_W-1:0]  rp_ff;
   logic [CNT_W-1:0]  held_ff;
   logic [1:0]        idx_ff;
   logic [1:0]        last_ff;
   logic [1:0]        fault_ff;
   logic [WORD_W-1:0] words_ff  [QUAD_WORDS];
   logic [WORD_W-1:0] popped_ff [QUAD_WORDS];
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   state_type         state_in;
   logic [CNT_W-1:0]  held_in;
   logic [1:0]        fault_in;
   logic [2:0]        eff_cnt;
   logic [CNT_W-1:0]  free_words;
   logic              req_accept;

   addr_op_type       addr_op;
   logic [PTR_W-1:0]  addr_ptr;
   logic [PTR_W-1:0]  addr_out;

   logic              ring_wr_en;
   logic [WORD_W-1:0] ring_wr_data;
   logic              ring_rd_en;
   logic [PTR_W-1:0]  ring_rd_addr;
   logic [WORD_W-1:0] ring_rd_data;

   logic              step_last;
   logic              rsp_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign step_last  = (idx_ff == last_ff);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // request decode: fault check and new fill level are settled at accept
   always_comb begin
      eff_cnt    = (req_data.word_count > 3'(QUAD_WORDS)) ? 3'(QUAD_WORDS)
                                                           : req_data.word_count;
      free_words = CNT_W'(RING_DEPTH) - held_ff;
      state_in   = ST_DONE;
      held_in    = held_ff;
      fault_in   = FAULT_OK;
      unique case (req_data.action)
         ACT_PUSH: begin
            if (CNT_W'(eff_cnt) > free_words) begin
               fault_in = FAULT_OVERFLOW;
            end else if (eff_cnt != 3'd0) begin
               state_in = ST_PUSH;
               held_in  = held_ff + CNT_W'(eff_cnt);
            end
         end
         ACT_POP: begin
            if (CNT_W'(eff_cnt) > held_ff) begin
               fault_in = FAULT_UNDERFLOW;
            end else if (eff_cnt != 3'd0) begin
               state_in = ST_POP_RD;
               held_in  = held_ff - CNT_W'(eff_cnt);
            end
         end
         ACT_PAD: begin
            if (req_data.word_count < 3'(QUAD_WORDS)) begin
               if (CNT_W'(req_data.word_count) > free_words) begin
                  fault_in = FAULT_OVERFLOW;
               end else if (req_data.word_count != 3'd0) begin
                  state_in = ST_PAD_RD;
                  held_in  = held_ff + CNT_W'(req_data.word_count);
               end
            end
         end
         default: begin
            state_in = ST_DONE;
         end
      endcase
   end

   // pointer unit operand select
   always_comb begin
      unique case (state_ff)
         ST_POP_RD: begin
            addr_op  = ADDR_INC;
            addr_ptr = rp_ff;
         end
         ST_PAD_RD: begin
            addr_op  = ADDR_BACK4;
            addr_ptr = wp_ff;
         end
         default: begin
            addr_op  = ADDR_INC;
            addr_ptr = wp_ff;
         end
      endcase
   end

   wfqp_addr_unit #(
      .RING_DEPTH (RING_DEPTH)
   ) u_addr_unit (
      .op      (addr_op),
      .ptr_in  (addr_ptr),
      .ptr_out (addr_out)
   );

   // pad word i is a copy of the word four places behind the write pointer
   assign ring_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_PUSH) ||
                         (state_ff == ST_PAD_WR);
   assign ring_wr_data = (state_ff == ST_CLEAR) ? '0 :
                         (state_ff == ST_PUSH)  ? words_ff[idx_ff] : ring_rd_data;
   assign ring_rd_en   = (state_ff == ST_POP_RD) || (state_ff == ST_PAD_RD);
   assign ring_rd_addr = (state_ff == ST_POP_RD) ? rp_ff : addr_out;

   wfqp_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (wp_ff),
      .wr_data (ring_wr_data),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         rp_ff        <= '0;
         held_ff      <= '0;
         idx_ff       <= '0;
         last_ff      <= '0;
         fault_ff     <= FAULT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         // ST_DONE handles the output register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               wp_ff <= addr_out;
               if (wp_ff == LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff     <= state_in;
                  held_ff      <= held_in;
                  fault_ff     <= fault_in;
                  idx_ff       <= '0;
                  last_ff      <= 2'(eff_cnt - 3'd1);
                  words_ff[0]  <= req_data.word_a;
                  words_ff[1]  <= req_data.word_b;
                  words_ff[2]  <= req_data.word_c;
                  words_ff[3]  <= req_data.word_d;
                  for (int i = 0; i < QUAD_WORDS; i++) begin
                     popped_ff[i] <= '0;
                  end
               end
            end
            ST_PUSH: begin
               wp_ff  <= addr_out;
               idx_ff <= idx_ff + 2'd1;
               if (step_last) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_POP_RD: begin
               rp_ff    <= addr_out;
               state_ff <= ST_POP_CAP;
            end
            ST_POP_CAP: begin
               popped_ff[idx_ff] <= ring_rd_data;
               idx_ff            <= idx_ff + 2'd1;
               state_ff          <= step_last ? ST_DONE : ST_POP_RD;
            end
            ST_PAD_RD: begin
               state_ff <= ST_PAD_WR;
            end
            ST_PAD_WR: begin
               wp_ff    <= addr_out;
               idx_ff   <= idx_ff + 2'd1;
               state_ff <= step_last ? ST_DONE : ST_PAD_RD;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_ff.out_word_a <= popped_ff[0];
                  rsp_ff.out_word_b <= popped_ff[1];
                  rsp_ff.out_word_c <= popped_ff[2];
                  rsp_ff.out_word_d <= popped_ff[3];
                  rsp_ff.fill_level <= 8'(held_ff);
                  rsp_ff.fault      <= fault_ff;
                  rsp_valid_ff      <= 1'b1;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/wfqp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the word FIFO with quadword pad, bound to the top level.
module wfqp_checker import wfqp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // clearing pass follows reset, no request taken then
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request accepted right after reset");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while busy");

   // a dropped pop returns no words
   a_underflow_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.fault == FAULT_UNDERFLOW) |->
         (rsp_data.out_word_a == '0 && rsp_data.out_word_b == '0 &&
          rsp_data.out_word_c == '0 && rsp_data.out_word_d == '0))
      else $error("words returned on underflow");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind word_fifo_with_quadword_pad_unit wfqp_checker u_wfqp_checker (.*);

// ===== test/tb_word_fifo_with_quadword_pad_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench: word FIFO with quadword pad, against its own ring predictor.
module tb_word_fifo_with_quadword_pad_unit;
   import wfqp_pkg::*;

   localparam int RING_DEPTH  = 128;
   localparam int RANDOM_REQS = 450;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_WAIT  = 24;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Ring predictor plus the queue of responses it has worked out.
   class ring_scoreboard;
      logic [WORD_W-1:0] ring [RING_DEPTH];
      int wr_ptr;
      int rd_ptr;
      int held;
      rsp_type predicted_rsp [$];
      int errors;
      int reported;

      function new();
         foreach (ring[k]) ring[k] = '0;
         wr_ptr   = 0;
         rd_ptr   = 0;
         held     = 0;
         errors   = 0;
         reported = 0;
      endfunction

      function void take_request(req_type r);
         logic [WORD_W-1:0] src [QUAD_WORDS];
         logic [WORD_W-1:0] spare [QUAD_WORDS];
         logic [WORD_W-1:0] popped [QUAD_WORDS];
         logic [1:0] fault;
         rsp_type want;
         int n;
         int base;
         int free_words;
         src[0] = r.word_a;
         src[1] = r.word_b;
         src[2] = r.word_c;
         src[3] = r.word_d;
         foreach (popped[k]) popped[k] = '0;
         fault      = FAULT_OK;
         free_words = RING_DEPTH - held;
         n          = r.word_count;
         if ((r.action == ACT_PUSH || r.action == ACT_POP) && n > QUAD_WORDS)
            n = QUAD_WORDS;
         case (r.action)
            ACT_PUSH: begin
               if (n > free_words) begin
                  fault = FAULT_OVERFLOW;
               end else begin
                  for (int i = 0; i < n; i++) ring[(wr_ptr + i) % RING_DEPTH] = src[i];
                  wr_ptr = (wr_ptr + n) % RING_DEPTH;
                  held += n;
               end
            end
            ACT_POP: begin
               if (n > held) begin
                  fault = FAULT_UNDERFLOW;
               end else begin
                  for (int i = 0; i < n; i++) popped[i] = ring[(rd_ptr + i) % RING_DEPTH];
                  rd_ptr = (rd_ptr + n) % RING_DEPTH;
                  held -= n;
               end
            end
            ACT_PAD: begin
               if (n < QUAD_WORDS) begin
                  if (n > free_words) begin
                     fault = FAULT_OVERFLOW;
                  end else begin
                     // earlier whole quadword starts 4 + (4 - n) words back
                     base = (wr_ptr + 2 * RING_DEPTH - QUAD_WORDS - (QUAD_WORDS - n))
                            % RING_DEPTH;
                     for (int i = 0; i < QUAD_WORDS; i++)
                        spare[i] = ring[(base + i) % RING_DEPTH];
                     for (int i = 0; i < n; i++)
                        ring[(wr_ptr + i) % RING_DEPTH] = spare[(QUAD_WORDS - n + i) % QUAD_WORDS];
                     wr_ptr = (wr_ptr + n) % RING_DEPTH;
                     held += n;
                  end
               end
            end
            default: ;
         endcase
         want.out_word_a = popped[0];
         want.out_word_b = popped[1];
         want.out_word_c = popped[2];
         want.out_word_d = popped[3];
         want.fill_level = 8'(held);
         want.fault      = fault;
         predicted_rsp.push_back(want);
      endfunction

      function void match_response(rsp_type got);
         rsp_type want;
         logic [WORD_W-1:0] w [6];
         logic [WORD_W-1:0] g [6];
         string names [6];
         if (predicted_rsp.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("unexpected response: %p", got);
            end
            return;
         end
         want  = predicted_rsp.pop_front();
         names = '{"out_word_a", "out_word_b", "out_word_c", "out_word_d", "fill_level",
                   "fault"};
         w = '{want.out_word_a, want.out_word_b, want.out_word_c, want.out_word_d,
               32'(want.fill_level), 32'(want.fault)};
         g = '{got.out_word_a, got.out_word_b, got.out_word_c, got.out_word_d,
               32'(got.fill_level), 32'(got.fault)};
         for (int k = 0; k < 6; k++) begin
            if (g[k] !== w[k]) begin
               errors++;
               if (reported < 10) begin
                  reported++;
                  $display("mismatch on %s: expected %h, got %h", names[k], w[k], g[k]);
               end
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   ring_scoreboard sb;
   int cycle_count = 0;
   int burst_left  = 0;
   int stretch_left = 0;
   int stall_pct    = 0;

   word_fifo_with_quadword_pad_unit #(
      .RING_DEPTH(RING_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL word_fifo_with_quadword_pad_unit");
         $finish;
      end
   end

   // Receiver stall pattern: stretches of random length, each with its own stall rate.
   always @(negedge clock) begin
      if (stretch_left == 0) begin
         stretch_left = $urandom_range(8, 64);
         case ($urandom_range(3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 85;
         endcase
      end else begin
         stretch_left--;
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.match_response(rsp_data);
   end

   function automatic req_type build_req(logic [1:0] act, logic [2:0] cnt,
                                         logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                         logic [WORD_W-1:0] c, logic [WORD_W-1:0] d);
      req_type r;
      r.action     = act;
      r.word_count = cnt;
      r.word_a     = a;
      r.word_b     = b;
      r.word_c     = c;
      r.word_d     = d;
      return r;
   endfunction

   // Send one request inside the current burst; open a new burst, sometimes after a gap, when it runs out.
   task automatic issue(req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.take_request(r);
      burst_left--;
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_valid  <= 1'b0;
      burst_left = 0;
      while (sb.predicted_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase();
      req_type r;
      logic [1:0] act;
      logic [2:0] cnt;
      int counted;
      int pick;
      bit filling;
      bit paused;
      counted = 0;
      filling = 1'b1;
      paused  = 1'b0;
      while (counted < RANDOM_REQS) begin
         // swing the fill level between empty and full so both faults come up
         if (filling && sb.held >= RING_DEPTH - 4 && $urandom_range(2) == 0)
            filling = 1'b0;
         else if (!filling && sb.held <= 3 && $urandom_range(2) == 0)
            filling = 1'b1;
         pick = $urandom_range(99);
         if (filling)
            act = (pick < 65) ? ACT_PUSH : (pick < 80) ? ACT_PAD :
                  (pick < 95) ? ACT_POP : ACT_UNUSED;
         else
            act = (pick < 65) ? ACT_POP : (pick < 80) ? ACT_PUSH :
                  (pick < 92) ? ACT_PAD : ACT_UNUSED;
         if (act == ACT_PAD)
            cnt = ($urandom_range(5) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
         else
            cnt = 3'($urandom_range(7));
         r = build_req(act, cnt, $urandom, $urandom, $urandom, $urandom);
         issue(r);
         counted++;
         if (counted == RANDOM_REQS / 2 && !paused) begin
            paused = 1'b1;
            pause_until_drained();
         end
      end
   endtask

   initial begin
      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      issue(build_req(ACT_POP, 3'd1, '0, '0, '0, '0));       // pop on empty ring
      issue(build_req(ACT_PAD, 3'd3, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_PUSH, 3'd0, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_PUSH, 3'd4, '1, '1, '1, '1));
      issue(build_req(ACT_PUSH, 3'd4, '0, '0, '0, '0));
      issue(build_req(ACT_PUSH, 3'd5, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_PUSH, 3'd2, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_PAD, 3'd2, '1, '1, '1, '1));
      issue(build_req(ACT_PAD, 3'd1, '0, '0, '0, '0));
      issue(build_req(ACT_PAD, 3'd0, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_PAD, 3'd3, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_PAD, 3'd4, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_PAD, 3'd7, '1, '1, '1, '1));
      issue(build_req(ACT_UNUSED, 3'd7, '1, '1, '1, '1));
      issue(build_req(ACT_POP, 3'd0, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_POP, 3'd7, '1, '1, '1, '1));
      issue(build_req(ACT_POP, 3'd4, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_POP, 3'd3, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_POP, 3'd2, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_POP, 3'd1, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_PUSH, 3'd6, $urandom, $urandom, $urandom, $urandom));
      issue(build_req(ACT_PUSH, 3'd7, '1, '0, '1, '0));
      issue(build_req(ACT_POP, 3'd5, $urandom, $urandom, $urandom, $urandom));
      pause_until_drained();

      random_phase();

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.predicted_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.errors == 0 && sb.predicted_rsp.size() == 0)
         $display("PASS word_fifo_with_quadword_pad_unit");
      else
         $display("FAIL word_fifo_with_quadword_pad_unit");
      $finish;
   end

endmodule
